// ===== hw/rtl/kruskal_mst_weight_defines.svh =====
// assertion macros for the spanning forest block checker
// used by kmw_checker only, needs a clk and rst in scope
`ifndef KRUSKAL_MST_WEIGHT_DEFINES_SVH
`define KRUSKAL_MST_WEIGHT_DEFINES_SVH

// same-cycle implication, ignored while in reset
`define KMW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kmw assertion failed");

// next-cycle implication, ignored while in reset
`define KMW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kmw assertion failed");

`endif

// ===== hw/rtl/kmw_pkg.sv =====
// shared types and constants for the spanning forest weight block
// no dependencies
package kmw_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES    = 4096;
  localparam int VERT_W  = $clog2(MAX_VERTICES);
  localparam int EIDX_W  = $clog2(MAX_EDGES);
  localparam int CNT_W   = EIDX_W + 1;
  localparam int VC_W    = 11;
  localparam int WT_W    = 48;
  localparam int SUM_W   = 63;
  localparam int RANK_W  = 4;
  localparam logic [RANK_W-1:0] RANK_MAX = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 64;

  typedef struct packed {
    logic [WT_W-1:0]   weight;
    logic [VERT_W-1:0] to;
    logic [VERT_W-1:0] from;
  } edge_rec_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_INS_RD, OP_INS_SHIFT, OP_INS_PUT, OP_CLR,
    OP_WALK_START, OP_EDGE_RD, OP_EDGE_LATCH, OP_FIND_RD, OP_FIND_STEP,
    OP_COMP_STEP, OP_NEXT_SIDE, OP_ADD_RD_A, OP_RD_B, OP_UNION,
    OP_NEXT_EDGE, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic store_full;
    logic pos_zero;
    logic mem_gt;
    logic new_last;
    logic clr_last;
    logic ends_ok;
    logic root_hit;
    logic at_root;
    logic side_b;
    logic same_set;
    logic edge_last;
    logic out_busy;
  } dp_status_t;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_INS_CHK, ST_INS_RD, ST_INS_CMP, ST_INS_PUT, ST_WALK,
    ST_EDGE_RD, ST_EDGE_LAT, ST_EDGE_CHK, ST_FRD, ST_FSTEP, ST_CCHK, ST_CRD,
    ST_CSTEP, ST_SIDE_DONE, ST_MERGE, ST_RK_A, ST_RK_B, ST_UNION, ST_NEXT,
    ST_EMIT
  } kmw_state_t;

endpackage

// ===== hw/rtl/kruskal_mst_weight.sv =====
// top level of the spanning forest weight block
// depends on kmw_pkg, kmw_ctrl, kmw_datapath
//
//  channel  | direction | handshake          | payload
//  s_*      | in        | s_tvalid/s_tready  | edge in s_tdata, last edge on s_tlast
//  m_*      | out       | m_tvalid/m_tready  | forest weight in m_tdata, overflow in m_tuser
//  cfg_*    | in        | cfg_we             | vertex count, no read-back
//
// an edge is sorted in by weight: each heavier stored edge moves up one place
// walk: skip an edge with an endpoint out of range, else find roots, join sets if apart
// after reset and after each result a sweep over every vertex clears the set store
// the result waits in an output register; the sweep runs while it waits
// requests are taken only while idle, so the input stalls from the last edge until the sweep ends
module kruskal_mst_weight import kmw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // edge_from, edge_to, edge_weight, zero pad
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // total_weight, zero pad
  output logic                  m_tuser,   // edge_overflow
  input  logic                  cfg_we,
  input  logic [VC_W-1:0]       cfg_wdata
);

  dp_op_t          op;
  dp_status_t      status;
  logic [VC_W-1:0] vertex_count;
  edge_rec_t       in_edge;
  logic [SUM_W-1:0] out_sum;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VC_W'(1024);
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  assign in_edge = s_tdata[$bits(edge_rec_t)-1:0];
  assign m_tdata = {{(OUT_DATA_W-SUM_W){1'b0}}, out_sum};

  kmw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .op       (op),
    .status   (status)
  );

  kmw_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .status       (status),
    .vertex_count (vertex_count),
    .in_edge      (in_edge),
    .in_last      (s_tlast),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_sum      (out_sum),
    .out_ovf      (m_tuser)
  );

endmodule

// ===== hw/rtl/kmw_datapath.sv =====
// edge store, disjoint-set store, sum and result register
// depends on kmw_pkg
module kmw_datapath import kmw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_op_t                op,
  output dp_status_t            status,
  input  logic [VC_W-1:0]       vertex_count,
  input  edge_rec_t             in_edge,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SUM_W-1:0]      out_sum,
  output logic                  out_ovf
);

  // memories
  edge_rec_t         edge_mem [MAX_EDGES];
  logic [VERT_W-1:0] parent_mem [MAX_VERTICES];
  logic [RANK_W-1:0] rank_mem [MAX_VERTICES];

  edge_rec_t         edata;
  logic [VERT_W-1:0] pdata;
  logic [RANK_W-1:0] rdata;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  k;
  logic              overflow;
  edge_rec_t         nedge;
  logic              nlast;
  logic [VERT_W-1:0] ci;
  logic [VERT_W-1:0] ea, eb, cur, root, ra;
  logic [WT_W-1:0]   ew;
  logic              side;
  logic [RANK_W-1:0] rka;
  logic [SUM_W-1:0]  sum;

  logic [EIDX_W-1:0] e_raddr;
  logic [CNT_W-1:0]  pos_m1;
  logic [VC_W-1:0]   limit;
  logic [SUM_W:0]    sum_add;
  logic [VERT_W-1:0] p_raddr;

  assign pos_m1  = pos - CNT_W'(1);
  assign limit   = (vertex_count > VC_W'(MAX_VERTICES)) ? VC_W'(MAX_VERTICES) : vertex_count;
  assign sum_add = {1'b0, sum} + {{(SUM_W+1-WT_W){1'b0}}, ew};
  assign e_raddr = (op == OP_INS_RD) ? pos_m1[EIDX_W-1:0] : k[EIDX_W-1:0];
  assign p_raddr = cur;

  // edge store port
  always_ff @(posedge clk) begin
    if (op == OP_INS_SHIFT) begin
      edge_mem[pos[EIDX_W-1:0]] <= edata;
    end else if (op == OP_INS_PUT) begin
      edge_mem[pos[EIDX_W-1:0]] <= nedge;
    end
    edata <= edge_mem[e_raddr];
  end

  // parent store port
  always_ff @(posedge clk) begin
    if (op == OP_CLR) begin
      parent_mem[ci] <= ci;
    end else if (op == OP_COMP_STEP) begin
      parent_mem[cur] <= root;
    end else if (op == OP_UNION) begin
      if (rka < rdata) begin
        parent_mem[ra] <= root;
      end else begin
        parent_mem[root] <= ra;
      end
    end
    pdata <= parent_mem[p_raddr];
  end

  // rank store port
  always_ff @(posedge clk) begin
    if (op == OP_CLR) begin
      rank_mem[ci] <= '0;
    end else if (op == OP_UNION && rka == rdata && rka != RANK_MAX) begin
      rank_mem[ra] <= rka + RANK_W'(1);
    end
    rdata <= rank_mem[(op == OP_ADD_RD_A) ? ra : root];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      overflow  <= 1'b0;
      ci        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (op)
        OP_LOAD: begin
          if (count == CNT_W'(MAX_EDGES)) begin
            overflow <= 1'b1;
          end
        end
        OP_INS_PUT: count <= count + CNT_W'(1);
        OP_CLR:     ci <= ci + VERT_W'(1);
        OP_EMIT: begin
          out_valid <= 1'b1;
          count     <= '0;
          overflow  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        nedge <= in_edge;
        nlast <= in_last;
        pos   <= count;
      end
      OP_INS_SHIFT:  pos <= pos_m1;
      OP_WALK_START: begin
        k   <= '0;
        sum <= '0;
      end
      OP_EDGE_LATCH: begin
        ea   <= edata.from;
        eb   <= edata.to;
        ew   <= edata.weight;
        cur  <= edata.from;
        side <= 1'b0;
      end
      OP_FIND_STEP: begin
        if (pdata == cur) begin
          root <= cur;
          cur  <= side ? eb : ea;
        end else begin
          cur <= pdata;
        end
      end
      OP_COMP_STEP: cur <= pdata;
      OP_NEXT_SIDE: begin
        ra   <= root;
        cur  <= eb;
        side <= 1'b1;
      end
      OP_ADD_RD_A: begin
        sum <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
      end
      OP_RD_B:      rka <= rdata;
      OP_NEXT_EDGE: k <= k + CNT_W'(1);
      OP_EMIT: begin
        out_sum <= sum;
        out_ovf <= overflow;
      end
      default: ;
    endcase
  end

  // status back to the controller
  always_comb begin
    status.store_full = (count == CNT_W'(MAX_EDGES));
    status.pos_zero   = (pos == '0);
    status.mem_gt     = (edata.weight > nedge.weight);
    status.new_last   = nlast;
    status.clr_last   = (ci == VERT_W'(MAX_VERTICES - 1));
    status.ends_ok    = ({1'b0, ea} < limit) && ({1'b0, eb} < limit);
    status.root_hit   = (pdata == cur);
    status.at_root    = (cur == root);
    status.side_b     = side;
    status.same_set   = (ra == root);
    status.edge_last  = ((k + CNT_W'(1)) == count);
    status.out_busy   = out_valid;
  end

endmodule

// ===== hw/rtl/kmw_ctrl.sv =====
// sequencer for loading, insertion sort, union-find walk and clearing
// depends on kmw_pkg
module kmw_ctrl import kmw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output dp_op_t     op,
  input  dp_status_t status
);

  kmw_state_t state, state_next;

  // state register, reset starts with a clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath command
  always_comb begin
    state_next = state;
    op         = OP_NONE;
    in_ready   = 1'b0;
    case (state)
      ST_CLR: begin
        op = OP_CLR;
        if (status.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = OP_LOAD;
          if (!status.store_full) state_next = ST_INS_CHK;
          else state_next = ST_WALK;
        end
      end
      ST_INS_CHK: begin
        state_next = status.pos_zero ? ST_INS_PUT : ST_INS_RD;
      end
      ST_INS_RD: begin
        op = OP_INS_RD;
        state_next = ST_INS_CMP;
      end
      ST_INS_CMP: begin
        if (status.mem_gt) begin
          op = OP_INS_SHIFT;
          state_next = ST_INS_CHK;
        end else begin
          state_next = ST_INS_PUT;
        end
      end
      ST_INS_PUT: begin
        op = OP_INS_PUT;
        state_next = status.new_last ? ST_WALK : ST_IDLE;
      end
      ST_WALK: begin
        if (status.new_last) begin
          op = OP_WALK_START;
          state_next = ST_EDGE_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EDGE_RD: begin
        op = OP_EDGE_RD;
        state_next = ST_EDGE_LAT;
      end
      ST_EDGE_LAT: begin
        op = OP_EDGE_LATCH;
        state_next = ST_EDGE_CHK;
      end
      ST_EDGE_CHK: begin
        state_next = status.ends_ok ? ST_FRD : ST_NEXT;
      end
      // root search, a parent read and then a step toward the root
      ST_FRD: begin
        op = OP_FIND_RD;
        state_next = ST_FSTEP;
      end
      ST_FSTEP: begin
        op = OP_FIND_STEP;
        state_next = status.root_hit ? ST_CCHK : ST_FRD;
      end
      // path compression walk
      ST_CCHK: begin
        state_next = status.at_root ? ST_SIDE_DONE : ST_CRD;
      end
      ST_CRD: begin
        op = OP_FIND_RD;
        state_next = ST_CSTEP;
      end
      ST_CSTEP: begin
        op = OP_COMP_STEP;
        state_next = ST_CCHK;
      end
      ST_SIDE_DONE: begin
        if (!status.side_b) begin
          op = OP_NEXT_SIDE;
          state_next = ST_FRD;
        end else begin
          state_next = ST_MERGE;
        end
      end
      ST_MERGE: begin
        state_next = status.same_set ? ST_NEXT : ST_RK_A;
      end
      ST_RK_A: begin
        op = OP_ADD_RD_A;
        state_next = ST_RK_B;
      end
      ST_RK_B: begin
        op = OP_RD_B;
        state_next = ST_UNION;
      end
      ST_UNION: begin
        op = OP_UNION;
        state_next = ST_NEXT;
      end
      ST_NEXT: begin
        op = OP_NEXT_EDGE;
        state_next = status.edge_last ? ST_EMIT : ST_EDGE_RD;
      end
      ST_EMIT: begin
        if (!status.out_busy) begin
          op = OP_EMIT;
          state_next = ST_CLR;
        end
      end
      default: state_next = ST_CLR;
    endcase
  end

endmodule

// ===== hw/rtl/kmw_checker.sv =====
// port-level checker for the spanning forest weight block, bound to the top
// depends on kruskal_mst_weight_defines.svh
`include "kruskal_mst_weight_defines.svh"
module kmw_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser
);

  // a stalled result holds
  `KMW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  // the input closes once the last edge of a graph is taken
  `KMW_ASSERT_NEXT(a_busy_after_last, s_tvalid && s_tready && s_tlast, !s_tready)
  // the top bit of the result is never set
  `KMW_ASSERT_NOW(a_sum_range, m_tvalid, !m_tdata[63])
  // a fresh result never appears on the same edge as an edge request
  `KMW_ASSERT_NOW(a_no_rise_on_load, $rose(m_tvalid), !$past(s_tvalid && s_tready))

endmodule

bind kruskal_mst_weight kmw_checker u_kmw_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== tb/sv/kmw_checker.sv =====
// checker for the spanning forest weight block: watches edge, result and config channels
// depends on kmw_pkg; predicts each graph's forest weight and compares it with the result
`timescale 1ns / 1ps

module kmw_scoreboard import kmw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tlast,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  m_tuser,
  input  logic                  cfg_we,
  input  logic [VC_W-1:0]       cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output int                    graphs_done
);

  typedef struct {
    logic [SUM_W-1:0] forest_sum;
    logic             dropped;
  } forest_res_t;

  forest_res_t      forest_q[$];
  logic [WT_W-1:0]  held_wt  [MAX_EDGES];
  logic [VERT_W-1:0] held_from[MAX_EDGES];
  logic [VERT_W-1:0] held_to  [MAX_EDGES];
  int               held_cnt;
  logic             lost_edges;
  logic [VC_W-1:0]  vert_count;
  int               parent_of[MAX_VERTICES];
  int               rank_of  [MAX_VERTICES];

  // keep held edges in ascending weight order
  function automatic void hold_edge(logic [VERT_W-1:0] f, logic [VERT_W-1:0] t,
                                    logic [WT_W-1:0] w);
    int pos;
    pos = held_cnt;
    while (pos > 0 && held_wt[pos-1] > w) begin
      held_wt[pos]   = held_wt[pos-1];
      held_from[pos] = held_from[pos-1];
      held_to[pos]   = held_to[pos-1];
      pos--;
    end
    held_wt[pos]   = w;
    held_from[pos] = f;
    held_to[pos]   = t;
    held_cnt++;
  endfunction

  // root search with path compression
  function automatic int find_root(int v);
    int r;
    int nxt;
    r = v;
    while (parent_of[r] != r) r = parent_of[r];
    while (parent_of[v] != r) begin
      nxt = parent_of[v];
      parent_of[v] = r;
      v = nxt;
    end
    return r;
  endfunction

  // kruskal walk over the held edges, saturating sum
  function automatic logic [SUM_W-1:0] forest_weight();
    int lim;
    int a;
    int b;
    int tmp;
    logic [SUM_W:0] acc;
    lim = (vert_count > MAX_VERTICES) ? MAX_VERTICES : int'(vert_count);
    for (int i = 0; i < MAX_VERTICES; i++) begin
      parent_of[i] = i;
      rank_of[i] = 0;
    end
    acc = '0;
    for (int k = 0; k < held_cnt; k++) begin
      a = int'(held_from[k]);
      b = int'(held_to[k]);
      if (a >= lim || b >= lim) continue;
      a = find_root(a);
      b = find_root(b);
      if (a == b) continue;
      acc = acc + {{(SUM_W+1-WT_W){1'b0}}, held_wt[k]};
      if (acc > {1'b0, SUM_MAX}) acc = {1'b0, SUM_MAX};
      if (rank_of[a] < rank_of[b]) begin
        tmp = a; a = b; b = tmp;
      end
      parent_of[b] = a;
      if (rank_of[a] == rank_of[b] && rank_of[a] < 15) rank_of[a]++;
    end
    return acc[SUM_W-1:0];
  endfunction

  // watch the channels
  always @(posedge clk) begin
    forest_res_t exp_res;
    edge_rec_t   rec;
    if (rst) begin
      held_cnt    <= 0;
      lost_edges  <= 1'b0;
      vert_count  <= 11'd1024;
      fail_count  <= 0;
      graphs_done <= 0;
    end else begin
      if (cfg_we) vert_count = cfg_wdata;
      // incoming edge request
      if (s_tvalid && s_tready) begin
        rec = s_tdata[$bits(edge_rec_t)-1:0];
        if (held_cnt < MAX_EDGES) hold_edge(rec.from, rec.to, rec.weight);
        else lost_edges = 1'b1;
        if (s_tlast) begin
          exp_res.forest_sum = forest_weight();
          exp_res.dropped    = lost_edges;
          forest_q.push_back(exp_res);
          held_cnt   = 0;
          lost_edges = 1'b0;
        end
      end
      // outgoing result
      if (m_tvalid && m_tready) begin
        if (forest_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result sum=%0d ovf=%0b",
                                        m_tdata[SUM_W-1:0], m_tuser);
          fail_count = fail_count + 1;
        end else begin
          exp_res = forest_q.pop_front();
          graphs_done = graphs_done + 1;
          if (m_tdata[SUM_W-1:0] !== exp_res.forest_sum || m_tuser !== exp_res.dropped) begin
            if (fail_count < 10)
              $display("result %0d mismatch: sum exp %0d got %0d, ovf exp %0b got %0b",
                       graphs_done, exp_res.forest_sum, m_tdata[SUM_W-1:0],
                       exp_res.dropped, m_tuser);
            fail_count = fail_count + 1;
          end
        end
      end
    end
    pending = forest_q.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// top of the spanning forest weight testbench: clock, reset, edge and config stimulus
// depends on kmw_pkg, kruskal_mst_weight and kmw_scoreboard
`timescale 1ns / 1ps

module testbench;
  import kmw_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // edge_from, edge_to, edge_weight, zero pad
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // total_weight, zero pad
  logic                  m_tuser;        // edge_overflow
  logic                  cfg_we = 1'b0;
  logic [VC_W-1:0]       cfg_wdata = '0;

  int   fail_count;
  int   pending;
  int   graphs_done;
  logic edge_taken = 1'b0;
  logic quiet = 1'b0;
  logic hold_req = 1'b0;
  int   edges_sent = 0;
  int   cur_vc = 1024;

  always #1 clk = ~clk;

  kruskal_mst_weight dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  kmw_scoreboard chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending), .graphs_done(graphs_done)
  );

  // edge request handshake seen at the rising edge
  always @(posedge clk) edge_taken <= s_tvalid && s_tready;

  // result side: random stalls, one long hold on request
  always @(negedge clk) begin
    if (hold_req) begin
      m_tready <= 1'b0;
      repeat (4000) @(negedge clk);
      hold_req = 1'b0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, 16) - 1) @(negedge clk);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // offer one edge and wait until it is taken
  task automatic send_edge(int f, int t, logic [WT_W-1:0] w, bit last, bit gaps);
    edge_rec_t rec;
    if (gaps && !quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    rec.from   = VERT_W'(f);
    rec.to     = VERT_W'(t);
    rec.weight = w;
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - $bits(edge_rec_t)){1'b0}}, rec};
    s_tlast  <= last;
    do @(negedge clk); while (!edge_taken);
    edges_sent++;
  endtask

  // write the vertex count once the block has gone idle
  task automatic set_vertices(int vc);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (1200) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= VC_W'(vc);
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_vc = vc;
  endtask

  function automatic logic [WT_W-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return '1;
      1:       return '0;
      2, 3:    return WT_W'($urandom_range(0, 15));
      default: return WT_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic int pick_vertex();
    int lim;
    lim = (cur_vc > MAX_VERTICES) ? MAX_VERTICES : cur_vc;
    if (lim == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, 1023);
    return $urandom_range(0, lim - 1);
  endfunction

  // run limit
  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int vc_set[10] = '{1, 2, 3, 8, 33, 200, 1024, 0, 2047, 1500};
    int n;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, ties, self loop, reversed pair
    send_edge(0, 1023, '1, 0, 0);
    send_edge(1023, 0, '0, 0, 0);
    send_edge(5, 5, 7, 0, 0);
    send_edge(1, 2, 3, 0, 0);
    send_edge(2, 1, 3, 0, 0);
    send_edge(1023, 1, '1, 1, 0);
    send_edge(682, 341, 48'haaaa_aaaa_aaaa, 1, 0);
    // out-of-range endpoints with a small vertex count
    set_vertices(4);
    send_edge(0, 3, 9, 0, 0);
    send_edge(3, 4, 1, 0, 0);
    send_edge(1023, 2, 1, 0, 0);
    send_edge(1, 2, 48'h5555_5555_5555, 1, 0);
    // no vertex in use, then an oversized count
    set_vertices(0);
    send_edge(0, 0, 1, 0, 0);
    send_edge(0, 1, 2, 1, 0);
    set_vertices(2047);
    send_edge(1023, 1022, 4, 0, 0);
    send_edge(0, 1023, '1, 1, 0);
    set_vertices(1);
    send_edge(0, 0, 5, 1, 0);
    set_vertices(1024);

    // random graphs over several vertex counts
    hold_req = 1'b1;
    n = 0;
    while (n < 650) begin
      if (!hold_req && $urandom_range(0, 2) == 0) set_vertices(vc_set[$urandom_range(0, 9)]);
      for (int g = $urandom_range(1, 6); g > 0 && n < 650; g--) begin
        int len;
        len = $urandom_range(1, 20);
        for (int e = 0; e < len; e++) begin
          quiet = (n >= 540);
          send_edge(pick_vertex(), pick_vertex(), pick_weight(), e == len - 1, 1);
          n++;
        end
      end
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (2000) @(negedge clk);
    $display("covered %0d edges and %0d spanning forest results", edges_sent, graphs_done);
    $display("vertex counts from 0 to 2047, out-of-range endpoints, ties and self loops included");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
